// ===== sv/bmp_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types, constants and helpers for the BMP byte-stream pixel decoder.
// ----------------------------------------------------------------------------
package bmp_pkg;

  // Largest image dimension; magnitudes above it clamp to it.
  localparam int unsigned MAX_DIM = 2048;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);

  // Header layout.
  localparam int unsigned PIXEL_DATA_OFFSET = 54;
  localparam int unsigned OFS_W             = 6;
  localparam logic [OFS_W-1:0] HDR_WIDTH_LO  = 6'h12;
  localparam logic [OFS_W-1:0] HDR_WIDTH_HI  = 6'h15;
  localparam logic [OFS_W-1:0] HDR_HEIGHT_LO = 6'h16;
  localparam logic [OFS_W-1:0] HDR_HEIGHT_HI = 6'h19;
  localparam logic [OFS_W-1:0] HDR_DEPTH_LO  = 6'h1C;
  localparam logic [OFS_W-1:0] HDR_DEPTH_HI  = 6'h1D;
  localparam logic [OFS_W-1:0] HDR_LAST      = 6'(PIXEL_DATA_OFFSET - 1);

  localparam logic [15:0] DEPTH_ARGB = 16'd32;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 1'b0,
    CFG_ORIGIN_Y = 1'b1
  } cfg_idx_t;

  localparam int unsigned ORIGIN_W = 11;
  localparam int unsigned COORD_W  = 12;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1,
    PH_PAD    = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [31:0]        pixel_color;
    logic               last_pixel;
  } out_item_t;

  // Absolute value of a signed 32-bit dimension, clamped at MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_magnitude(input logic [31:0] v);
    logic [31:0] m;
    m = v[31] ? (32'd0 - v) : v;
    if (m > 32'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM);
    end
    return m[DIM_W-1:0];
  endfunction

endpackage

// ===== sv/bmp_stream_to_pixels.sv =====
// ----------------------------------------------------------------------------
// bmp_stream_to_pixels
// Parses a 24/32-bit BMP byte stream and emits one screen-placed ARGB pixel
// for each completed pixel of the image.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | in_item_t  (file byte, start)
//  out_    | output    | out_valid / out_stall | out_item_t (x, y, colour, last)
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (origins)
//
// One byte is accepted every cycle while in_stall is low; its pixel, if it completes
// one, is registered into the output register, or into the skid register if the
// output is held. The parse state is updated in the accepting cycle, so no byte
// waits on another. This two-entry output buffer lets in_stall be a register: it
// rises only when both entries hold a result. Reset is synchronous and clears the
// parse state, the buffer and the origin registers; cfg_ready is always high.
module bmp_stream_to_pixels
  import bmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ORIGIN_W-1:0]  cfg_data
);

  logic [ORIGIN_W-1:0] origin_x_r, origin_y_r;

  phase_t           phase_r, phase_nxt;
  logic [OFS_W-1:0] byte_offset_r, byte_offset_nxt;
  logic [31:0]      image_width_r, image_width_nxt;
  logic [31:0]      image_height_r, image_height_nxt;
  logic [15:0]      bit_depth_r, bit_depth_nxt;
  logic [1:0]       pixel_byte_index_r, pixel_byte_index_nxt;
  logic [23:0]      color_accum_r, color_accum_nxt;
  logic [DIM_W-1:0] column_count_r, column_count_nxt;
  logic [DIM_W-1:0] row_count_r, row_count_nxt;
  logic [1:0]       pad_remaining_r, pad_remaining_nxt;
  logic [DIM_W-1:0] width_mag_r, width_mag_nxt;
  logic [DIM_W-1:0] height_mag_r, height_mag_nxt;
  logic [1:0]       row_pad_r, row_pad_nxt;
  logic             need4_r, need4_nxt;

  logic      out_valid_r, skid_valid_r;
  out_item_t out_item_r, skid_item_r;

  logic      in_accept, out_take;
  logic      res_valid;
  out_item_t res_item;

  // Parse helpers.
  phase_t           cur_phase;
  logic [OFS_W-1:0] cur_offset;
  logic [DIM_W-1:0] hdr_width_mag, hdr_height_mag;
  logic [9:0]       pad_prod;
  logic             pixel_done;
  logic [23:0]      color_rgb;
  logic [DIM_W-1:0] col_pos, row_pos;
  logic             row_end, image_end;
  logic [1:0]       lane;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X: origin_x_r <= cfg_data;
        CFG_ORIGIN_Y: origin_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt            = phase_r;
    byte_offset_nxt      = byte_offset_r;
    image_width_nxt      = image_width_r;
    image_height_nxt     = image_height_r;
    bit_depth_nxt        = bit_depth_r;
    pixel_byte_index_nxt = pixel_byte_index_r;
    color_accum_nxt      = color_accum_r;
    column_count_nxt     = column_count_r;
    row_count_nxt        = row_count_r;
    pad_remaining_nxt    = pad_remaining_r;
    width_mag_nxt        = width_mag_r;
    height_mag_nxt       = height_mag_r;
    row_pad_nxt          = row_pad_r;
    need4_nxt            = need4_r;
    res_valid            = 1'b0;
    pixel_done           = 1'b0;
    color_rgb            = color_accum_r;
    lane                 = 2'd0;
    row_end              = 1'b0;
    image_end            = 1'b0;

    // A start-of-file byte is header byte zero, whatever the parse held.
    cur_phase  = in_data.start_of_file ? PH_HEADER : phase_r;
    cur_offset = in_data.start_of_file ? '0 : byte_offset_r;

    // The header fields are complete by the last header byte, so the derived
    // dimensions are worked out once there and held for the pixel array.
    hdr_width_mag  = dim_magnitude(image_width_r);
    hdr_height_mag = dim_magnitude(image_height_r);
    // Padding depends only on bits 4..3 of width * depth.
    pad_prod = hdr_width_mag[4:0] * bit_depth_r[4:0];

    col_pos = image_width_r[31] ? (width_mag_r - 1'b1 - column_count_r) : column_count_r;
    row_pos = image_height_r[31] ? row_count_r : (height_mag_r - 1'b1 - row_count_r);

    if (in_accept) begin
      if (in_data.start_of_file) begin
        pixel_byte_index_nxt = '0;
        column_count_nxt     = '0;
        row_count_nxt        = '0;
        pad_remaining_nxt    = '0;
      end
      unique case (cur_phase)
        PH_HEADER: begin
          lane = cur_offset[1:0] - HDR_WIDTH_LO[1:0];
          if (cur_offset >= HDR_WIDTH_LO && cur_offset <= HDR_WIDTH_HI) begin
            image_width_nxt[8*lane +: 8] = in_data.file_byte;
          end else if (cur_offset >= HDR_HEIGHT_LO && cur_offset <= HDR_HEIGHT_HI) begin
            image_height_nxt[8*lane +: 8] = in_data.file_byte;
          end else if (cur_offset >= HDR_DEPTH_LO && cur_offset <= HDR_DEPTH_HI) begin
            bit_depth_nxt[8*cur_offset[0] +: 8] = in_data.file_byte;
          end
          if (cur_offset >= HDR_LAST) begin
            byte_offset_nxt      = '0;
            pixel_byte_index_nxt = '0;
            column_count_nxt     = '0;
            row_count_nxt        = '0;
            width_mag_nxt        = hdr_width_mag;
            height_mag_nxt       = hdr_height_mag;
            row_pad_nxt          = 2'd0 - pad_prod[4:3];
            need4_nxt            = (bit_depth_r == DEPTH_ARGB);
            phase_nxt = (hdr_width_mag == '0 || hdr_height_mag == '0) ? PH_DONE : PH_PIXEL;
          end else begin
            byte_offset_nxt = cur_offset + 1'b1;
            phase_nxt       = PH_HEADER;
          end
        end
        PH_PAD: begin
          pad_remaining_nxt = pad_remaining_r - 1'b1;
          if (pad_remaining_r == 2'd1) begin
            phase_nxt = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          case (pixel_byte_index_r)
            2'd0: color_rgb = {16'd0, in_data.file_byte};
            2'd1: color_rgb[15:8]  = in_data.file_byte;
            2'd2: color_rgb[23:16] = in_data.file_byte;
            default: ;
          endcase
          color_accum_nxt = color_rgb;
          pixel_done = need4_r ? (pixel_byte_index_r == 2'd3)
                               : (pixel_byte_index_r == 2'd2);
          pixel_byte_index_nxt = pixel_done ? 2'd0 : pixel_byte_index_r + 1'b1;
          if (pixel_done) begin
            res_valid = 1'b1;
            row_end   = ({1'b0, column_count_r} + 1'b1) >= {1'b0, width_mag_r};
            image_end = row_end && (({1'b0, row_count_r} + 1'b1) >= {1'b0, height_mag_r});
            if (row_end) begin
              column_count_nxt = '0;
              if (image_end) begin
                phase_nxt = PH_DONE;
              end else begin
                row_count_nxt     = row_count_r + 1'b1;
                pad_remaining_nxt = row_pad_r;
                if (row_pad_r != 2'd0) begin
                  phase_nxt = PH_PAD;
                end
              end
            end else begin
              column_count_nxt = column_count_r + 1'b1;
            end
          end
        end
        PH_DONE: phase_nxt = PH_DONE;
        default: ;
      endcase
    end

    res_item.pixel_x     = COORD_W'(origin_x_r) + COORD_W'(col_pos);
    res_item.pixel_y     = COORD_W'(origin_y_r) + COORD_W'(row_pos);
    res_item.pixel_color = {(need4_r ? in_data.file_byte : 8'd0), color_rgb};
    res_item.last_pixel  = image_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= PH_HEADER;
      byte_offset_r      <= '0;
      pixel_byte_index_r <= '0;
      column_count_r     <= '0;
      row_count_r        <= '0;
      pad_remaining_r    <= '0;
    end else begin
      phase_r            <= phase_nxt;
      byte_offset_r      <= byte_offset_nxt;
      pixel_byte_index_r <= pixel_byte_index_nxt;
      column_count_r     <= column_count_nxt;
      row_count_r        <= row_count_nxt;
      pad_remaining_r    <= pad_remaining_nxt;
    end
  end

  always_ff @(posedge clk) begin
    image_width_r  <= image_width_nxt;
    image_height_r <= image_height_nxt;
    bit_depth_r    <= bit_depth_nxt;
    color_accum_r  <= color_accum_nxt;
    width_mag_r    <= width_mag_nxt;
    height_mag_r   <= height_mag_nxt;
    row_pad_r      <= row_pad_nxt;
    need4_r        <= need4_nxt;
  end

  // Output register with a skid entry behind it. While the skid entry is
  // full no byte is accepted, so a new result never meets a full buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !out_take) begin
      skid_valid_r <= res_valid;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_item_r <= skid_item_r;
      end
    end else if (out_valid_r && !out_take) begin
      if (res_valid) begin
        skid_item_r <= res_item;
      end
    end else if (res_valid) begin
      out_item_r <= res_item;
    end
  end

endmodule
